FILE: sv/alt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alt_pkg - shared types and constants for the acquisition line tagger
// Header and result records passed between the pipeline stages.
// ----------------------------------------------------------------------------
package alt_pkg;

  localparam int unsigned TS_W   = 32;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned TAG_W  = 16;

  // scanner ticks to output time units
  localparam logic [TS_W-1:0]  ELAPSED_SCALE = 32'd2500;
  localparam logic [IDX_W-1:0] IDX_NONE      = 16'hFFFF;
  localparam logic [TAG_W-1:0] TAG_FORCED    = 16'd1;

  typedef struct packed {
    logic                    is_noise;
    logic                    dummy_marker;
    logic [TS_W-1:0]         timestamp;
    logic signed [IDX_W-1:0] set_index;
    logic signed [IDX_W-1:0] line_index;
    logic                    is_calibration;
    logic                    is_navigator;
    logic [TAG_W-1:0]        contrast_in;
    logic [TAG_W-1:0]        encoding_space_in;
  } hdr_t;

  typedef struct packed {
    logic signed [TS_W-1:0] time_since_sat;
    logic [TAG_W-1:0]       contrast_out;
    logic [TAG_W-1:0]       encoding_space_out;
    logic                   high_contrast;
  } res_t;

  // handshake between the tagging core and its neighbor stages
  typedef struct packed {
    logic take;  // header register hands its transaction on
    logic emit;  // result register loads a new result
  } stage_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/alt_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alt_in_reg - header input register
// Holds one header transaction until the tagging core consumes it.
// ----------------------------------------------------------------------------
module alt_in_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire alt_pkg::hdr_t hdr_in,
  input  wire logic          take,
  output logic               hdr_valid,
  output alt_pkg::hdr_t      hdr_out
);
  import alt_pkg::*;

  logic valid_r;
  hdr_t hdr_r;

  assign in_ready  = !valid_r || take;
  assign hdr_valid = valid_r;
  assign hdr_out   = hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hdr_r <= hdr_in;
    end
  end

endmodule
`default_nettype wire

FILE: sv/alt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alt_core - saturation timing and line order tagging
// Holds the tagging state and builds the result for the held header.
// ----------------------------------------------------------------------------
module alt_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          hdr_valid,
  input  wire alt_pkg::hdr_t hdr,
  input  wire logic          out_free,
  output alt_pkg::stage_ctrl_t ctrl,
  output alt_pkg::res_t      res
);
  import alt_pkg::*;

  logic             sat_pending_r, sat_pending_nxt;
  logic [TS_W-1:0]  sat_stamp_r, sat_stamp_nxt;
  logic [IDX_W-1:0] sat_set_r, sat_set_nxt;
  logic [IDX_W-1:0] last_set_r, last_set_nxt;
  logic [IDX_W-1:0] last_line_r, last_line_nxt;

  logic             is_dummy;
  logic             has_result;
  logic [IDX_W-1:0] sat_set_eff;
  logic             line_restart;
  logic [IDX_W-1:0] last_line_eff;
  logic             hc;
  logic [TS_W-1:0]  diff;
  logic [TS_W-1:0]  elapsed;

  always_comb begin
    is_dummy      = hdr.is_noise && hdr.dummy_marker;
    has_result    = !is_dummy && !hdr.is_navigator;
    ctrl.take     = hdr_valid && (!has_result || out_free);
    ctrl.emit     = ctrl.take && has_result;

    // the first header after a dummy binds the set
    sat_set_eff   = sat_pending_r ? hdr.set_index : sat_set_r;
    diff          = hdr.timestamp - sat_stamp_r;
    elapsed       = (hdr.set_index == sat_set_eff) ? diff * ELAPSED_SCALE : '0;

    line_restart  = (hdr.set_index != last_set_r) || (hdr.line_index == '0);
    last_line_eff = line_restart ? IDX_NONE : last_line_r;
    hc            = hdr.line_index < $signed(last_line_eff);

    res.time_since_sat     = elapsed;
    res.contrast_out       = hc ? TAG_FORCED : hdr.contrast_in;
    res.encoding_space_out = hc ? TAG_FORCED : hdr.encoding_space_in;
    res.high_contrast      = hc;
  end

  always_comb begin
    sat_pending_nxt = sat_pending_r;
    sat_stamp_nxt   = sat_stamp_r;
    sat_set_nxt     = sat_set_r;
    last_set_nxt    = last_set_r;
    last_line_nxt   = last_line_r;
    if (ctrl.take) begin
      if (is_dummy) begin
        sat_pending_nxt = 1'b1;
        sat_stamp_nxt   = hdr.timestamp;
      end else begin
        sat_pending_nxt = 1'b0;
        sat_set_nxt     = sat_set_eff;
        last_set_nxt    = hdr.set_index;
        last_line_nxt   = (hc || hdr.is_calibration) ? last_line_eff : hdr.line_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_pending_r <= 1'b0;
      sat_stamp_r   <= '0;
      sat_set_r     <= IDX_NONE;
      last_set_r    <= IDX_NONE;
      last_line_r   <= IDX_NONE;
    end else begin
      sat_pending_r <= sat_pending_nxt;
      sat_stamp_r   <= sat_stamp_nxt;
      sat_set_r     <= sat_set_nxt;
      last_set_r    <= last_set_nxt;
      last_line_r   <= last_line_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/alt_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alt_out_reg - result output register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module alt_out_reg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          emit,
  input  wire alt_pkg::res_t res_in,
  output logic               out_free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output alt_pkg::res_t      res_out
);
  import alt_pkg::*;

  logic valid_r;
  res_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_in;
    end
  end

endmodule
`default_nettype wire

FILE: sv/acquisition_line_tagger_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acquisition_line_tagger_top - acquisition header tagger
// Tags each header with saturation elapsed time and line order contrast.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one acquisition header per transaction.
//   Result channel (out_valid/out_ready): at most one result per header.
//   A noise header with the dummy marker, and any navigator header, updates
//   the tagging state and yields no result transaction.
// Timing:
//   Two register stages: a header accepted into the header register is tagged
//   there, and its result loads into the result register, which drives the out
//   ports; a full result register can stall the header between the two.
//   One header per cycle is sustained while the result register drains; the
//   bound is the single state update per cycle in the tagging core, which
//   feeds its own state back for the next header.
// Reset:
//   rst_n low clears both stage valids and returns the state to no pending
//   dummy, timestamp zero and set/line trackers at -1.
// Stall:
//   While out_ready is low a full result register holds; the header register
//   still takes one more transaction, and headers that give no result keep
//   draining. in_ready drops only when a result is waiting behind a full
//   output register.
// ----------------------------------------------------------------------------
module acquisition_line_tagger_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_is_noise,
  input  wire logic        in_dummy_marker,
  input  wire logic [31:0] in_timestamp,
  input  wire logic signed [15:0] in_set_index,
  input  wire logic signed [15:0] in_line_index,
  input  wire logic        in_is_calibration,
  input  wire logic        in_is_navigator,
  input  wire logic [15:0] in_contrast_in,
  input  wire logic [15:0] in_encoding_space_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [31:0] out_time_since_sat,
  output logic [15:0]      out_contrast_out,
  output logic [15:0]      out_encoding_space_out,
  output logic             out_high_contrast
);
  import alt_pkg::*;

  hdr_t        hdr_in;
  hdr_t        hdr_held;
  logic        hdr_valid;
  stage_ctrl_t ctrl;
  res_t        res_core;
  res_t        res_held;
  logic        out_free;

  // pack the header fields for the pipeline
  assign hdr_in = '{
    is_noise:          in_is_noise,
    dummy_marker:      in_dummy_marker,
    timestamp:         in_timestamp,
    set_index:         in_set_index,
    line_index:        in_line_index,
    is_calibration:    in_is_calibration,
    is_navigator:      in_is_navigator,
    contrast_in:       in_contrast_in,
    encoding_space_in: in_encoding_space_in
  };

  // stage one: hold the incoming header
  alt_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hdr_in    (hdr_in),
    .take      (ctrl.take),
    .hdr_valid (hdr_valid),
    .hdr_out   (hdr_held)
  );

  // tag the held header and advance the state
  alt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_valid (hdr_valid),
    .hdr       (hdr_held),
    .out_free  (out_free),
    .ctrl      (ctrl),
    .res       (res_core)
  );

  // stage two: hold the result for the receiver
  alt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (ctrl.emit),
    .res_in    (res_core),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_held)
  );

  // unpack the result fields onto the ports
  assign out_time_since_sat     = res_held.time_since_sat;
  assign out_contrast_out       = res_held.contrast_out;
  assign out_encoding_space_out = res_held.encoding_space_out;
  assign out_high_contrast      = res_held.high_contrast;

endmodule
`default_nettype wire

FILE: sv/alt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alt_checker - port level checks for the acquisition line tagger
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module alt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_time_since_sat,
  input wire logic [15:0] out_contrast_out,
  input wire logic [15:0] out_encoding_space_out,
  input wire logic        out_high_contrast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_time_since_sat)
      && $stable(out_contrast_out) && $stable(out_encoding_space_out)
      && $stable(out_high_contrast))
    else $error("stalled result changed");

  // high contrast forces both tags to one
  a_hc_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_contrast |-> out_contrast_out == 16'd1
      && out_encoding_space_out == 16'd1)
    else $error("high contrast result without forced tags");

  // input backpressure only behind a waiting result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // reset empties the result stage
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind acquisition_line_tagger_top alt_checker u_alt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_time_since_sat     (out_time_since_sat),
  .out_contrast_out       (out_contrast_out),
  .out_encoding_space_out (out_encoding_space_out),
  .out_high_contrast      (out_high_contrast)
);
`default_nettype wire
